FILE: src/hotkey_press_matcher_top_assert.svh
// Assertion macros for the hotkey press matcher checker
`ifndef HOTKEY_PRESS_MATCHER_TOP_ASSERT_SVH
`define HOTKEY_PRESS_MATCHER_TOP_ASSERT_SVH

// Same-cycle implication, held off during reset
`define HPM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset
`define HPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/hpm_pkg.sv
// Package for the hotkey press matcher: codes, defaults and match helpers
`default_nettype none

package hpm_pkg;

    // Parameter defaults
    localparam int KEY_COUNT_DEF    = 256;
    localparam int MAX_BINDINGS_DEF = 4;

    // Number of binding registers on the configuration port
    localparam int BIND_REGS = 4;

    // Field widths
    localparam int KIND_W  = 2;
    localparam int CODE_W  = 8;
    localparam int MODS_W  = 4;
    localparam int ID_W    = 4;
    localparam int WORD_W  = 16;
    localparam int COUNT_W = 3;
    localparam int CIDX_W  = 3;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_EVENT     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLEAR_KEY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR_ALL = 2'd2;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_BINDING_COUNT = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_BINDING_0     = 3'd1;

    // Modifier key codes
    localparam logic [CODE_W-1:0] KC_SHIFT  = 8'h10;
    localparam logic [CODE_W-1:0] KC_CTRL   = 8'h11;
    localparam logic [CODE_W-1:0] KC_ALT    = 8'h12;
    localparam logic [CODE_W-1:0] KC_LWIN   = 8'h5B;
    localparam logic [CODE_W-1:0] KC_RWIN   = 8'h5C;
    localparam logic [CODE_W-1:0] KC_LSHIFT = 8'hA0;
    localparam logic [CODE_W-1:0] KC_RALT   = 8'hA5;

    // Decoded binding word
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [MODS_W-1:0] mods;    // win, alt, shift, ctrl
        logic [CODE_W-1:0] key;
    } binding_t;

    // True for the modifier keys, whose events are ignored
    function automatic logic is_modifier(input logic [CODE_W-1:0] k);
        return (k == KC_SHIFT) || (k == KC_CTRL) || (k == KC_ALT) ||
               (k == KC_LWIN) || (k == KC_RWIN) ||
               ((k >= KC_LSHIFT) && (k <= KC_RALT));
    endfunction

    // A binding hits on an exact key and modifier set; id or key zero never hits
    function automatic logic binding_hit(input binding_t b,
                                         input logic [CODE_W-1:0] k,
                                         input logic [MODS_W-1:0] m);
        return (b.id != '0) && (b.key != '0) && (b.key == k) && (b.mods == m);
    endfunction

endpackage

`default_nettype wire

FILE: src/hotkey_press_matcher_top.sv
// Hotkey press matcher: key tracking memory and binding search
//
//  channel | signals                                   | dir | handshake
//  --------+-------------------------------------------+-----+-----------------
//  in      | kind key_code key_up ctrl/shift/alt/win   | in  | in_valid/in_ready
//  out     | hotkey_id swallow                         | out | out_valid/out_ready
//  cfg     | cfg_index cfg_wdata                       | in  | cfg_we, no wait
//
// One item per cycle sustained while out_ready is high; an accepted item waits in
// the input register, then loads the result register, which drives out_valid.
// Key state is read from the key memory at acceptance and written back as the
// item moves on; per-key valid flags make keys untouched since reset or clear all read zero.
// rst_n clears the key valid flags, the bindings and the item valid flags at once.
// A stalled result holds; the input register still takes one more item.
`default_nettype none

module hotkey_press_matcher_top #(
    parameter int KEY_COUNT    = hpm_pkg::KEY_COUNT_DEF,
    parameter int MAX_BINDINGS = hpm_pkg::MAX_BINDINGS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // input item channel
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [hpm_pkg::KIND_W-1:0] kind,
    input  wire logic [hpm_pkg::CODE_W-1:0] key_code,
    input  wire logic                       key_up,
    input  wire logic                       ctrl_held,
    input  wire logic                       shift_held,
    input  wire logic                       alt_held,
    input  wire logic                       win_held,
    // result channel
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [hpm_pkg::ID_W-1:0]        hotkey_id,
    output logic                            swallow,
    // configuration write port
    input  wire logic                       cfg_we,
    input  wire logic [hpm_pkg::CIDX_W-1:0] cfg_index,
    input  wire logic [hpm_pkg::WORD_W-1:0] cfg_wdata
);

    localparam int KEY_W    = $clog2(KEY_COUNT);
    localparam int BIND_USE = (MAX_BINDINGS < hpm_pkg::BIND_REGS) ?
                              MAX_BINDINGS : hpm_pkg::BIND_REGS;

    // Per-key tracking entry
    typedef struct packed {
        logic pressed;
        logic swallowed;
    } key_state_t;

    // Configuration registers
    logic [hpm_pkg::COUNT_W-1:0] binding_count_reg;
    hpm_pkg::binding_t           binding_reg [BIND_USE];

    // Input register
    logic                        s1_valid_reg;
    logic [hpm_pkg::KIND_W-1:0]  kind_reg;
    logic [hpm_pkg::CODE_W-1:0]  key_reg;
    logic                        key_up_reg;
    logic [hpm_pkg::MODS_W-1:0]  mods_reg;
    key_state_t                  key_rd_reg;

    // Result register
    logic                        out_valid_reg;
    logic [hpm_pkg::ID_W-1:0]    hotkey_id_reg;
    logic                        swallow_reg;

    // Key tracking memory and its valid flags
    key_state_t                  key_mem [KEY_COUNT];
    logic [KEY_COUNT-1:0]        key_valid_reg;

    logic                        advance;
    logic                        take;
    logic [KEY_W-1:0]            in_idx;
    logic [KEY_W-1:0]            idx;
    logic                        tracked;
    logic                        was_pressed;
    logic                        was_swallowed;
    logic                        hit_any;
    logic [hpm_pkg::ID_W-1:0]    hit_id;
    logic [hpm_pkg::ID_W-1:0]    id_next;
    logic                        sw_next;
    logic                        key_we;
    key_state_t                  key_wdata;
    logic                        clear_all;

    // Flow control: the item in the input register moves on when the result
    // register is free or being emptied
    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign take      = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign hotkey_id = hotkey_id_reg;
    assign swallow   = swallow_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            binding_count_reg <= '0;
            for (int i = 0; i < BIND_USE; i++)
            begin
                binding_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == hpm_pkg::CFG_BINDING_COUNT)
            begin
                binding_count_reg <= cfg_wdata[hpm_pkg::COUNT_W-1:0];
            end
            for (int i = 0; i < BIND_USE; i++)
            begin
                if (cfg_index == hpm_pkg::CFG_BINDING_0 + hpm_pkg::CIDX_W'(i))
                begin
                    binding_reg[i] <= cfg_wdata;
                end
            end
        end
    end

    // Input register: valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // Input register: payload and key memory read; a write to the same key at
    // this edge is passed straight across
    assign in_idx = key_code[KEY_W-1:0];

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            kind_reg   <= kind;
            key_reg    <= key_code;
            key_up_reg <= key_up;
            mods_reg   <= {win_held, alt_held, shift_held, ctrl_held};
            if (advance && key_we && (in_idx == idx))
            begin
                key_rd_reg <= key_wdata;
            end
            else
            begin
                key_rd_reg <= key_mem[in_idx];
            end
        end
    end

    // Key memory write as the held item moves on
    always_ff @(posedge clk)
    begin
        if (advance && key_we)
        begin
            key_mem[idx] <= key_wdata;
        end
    end

    // Key valid flags: set on write, all dropped by clear all
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_valid_reg <= '0;
        end
        else if (advance)
        begin
            if (clear_all)
            begin
                key_valid_reg <= '0;
            end
            else if (key_we)
            begin
                key_valid_reg[idx] <= 1'b1;
            end
        end
    end

    // Key state lookup for the held item
    assign idx           = key_reg[KEY_W-1:0];
    assign tracked       = ({1'b0, key_reg} < (hpm_pkg::CODE_W + 1)'(KEY_COUNT));
    assign was_pressed   = tracked && key_valid_reg[idx] && key_rd_reg.pressed;
    assign was_swallowed = tracked && key_valid_reg[idx] && key_rd_reg.swallowed;

    // Binding search, first hit in order wins
    always_comb
    begin
        hit_any = 1'b0;
        hit_id  = '0;
        for (int i = BIND_USE - 1; i >= 0; i--)
        begin
            if ((hpm_pkg::COUNT_W'(i) < binding_count_reg) &&
                hpm_pkg::binding_hit(binding_reg[i], key_reg, mods_reg))
            begin
                hit_any = 1'b1;
                hit_id  = binding_reg[i].id;
            end
        end
    end

    // Item decode: result and key state update
    always_comb
    begin
        key_we    = 1'b0;
        key_wdata = '0;
        clear_all = 1'b0;
        id_next   = '0;
        sw_next   = 1'b0;
        case (kind_reg)
            hpm_pkg::KIND_CLEAR_KEY:
            begin
                if (tracked)
                begin
                    key_we            = 1'b1;
                    key_wdata.pressed = was_pressed;
                end
            end
            hpm_pkg::KIND_CLEAR_ALL:
            begin
                clear_all = 1'b1;
            end
            hpm_pkg::KIND_EVENT:
            begin
                if (tracked && !hpm_pkg::is_modifier(key_reg))
                begin
                    key_we = 1'b1;
                    if (key_up_reg)
                    begin
                        // release: report and drop any swallow mark
                        sw_next = was_swallowed;
                    end
                    else if (was_pressed)
                    begin
                        // auto-repeat keeps the stored decision
                        key_wdata.pressed   = 1'b1;
                        key_wdata.swallowed = was_swallowed;
                        sw_next             = was_swallowed;
                    end
                    else
                    begin
                        key_wdata.pressed   = 1'b1;
                        key_wdata.swallowed = was_swallowed || hit_any;
                        if (hit_any)
                        begin
                            id_next = hit_id;
                            sw_next = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            hotkey_id_reg <= id_next;
            swallow_reg   <= sw_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/hpm_checker.sv
// Port-level checker for the hotkey press matcher, with its bind
`default_nettype none

`include "hotkey_press_matcher_top_assert.svh"

module hpm_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       in_valid,
    input wire logic                       in_ready,
    input wire logic                       out_valid,
    input wire logic                       out_ready,
    input wire logic [hpm_pkg::ID_W-1:0]   hotkey_id,
    input wire logic                       swallow
);

    // A stalled result holds its item
    `HPM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(hotkey_id) && $stable(swallow), "result changed while stalled")

    // A fired hotkey always consumes the event
    `HPM_ASSERT_NOW(a_id_swallows, clk, rst_n, out_valid && (hotkey_id != '0), swallow, "hotkey fired without swallow")

    // With the result side draining, the input side never stalls
    `HPM_ASSERT_NOW(a_ready_flow, clk, rst_n, out_ready, in_ready, "input stalled while output drains")

    // A new result follows an accepted item that has passed through the input register
    `HPM_ASSERT_NOW(a_out_source, clk, rst_n, $rose(out_valid), $past(in_valid && in_ready, 2), "result without accepted item")

endmodule

bind hotkey_press_matcher_top hpm_checker u_hpm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hotkey_id (hotkey_id),
    .swallow   (swallow)
);

`default_nettype wire
